FILE: rtl/core/hpa_pkg.sv
// ============================================================================
// hpa_pkg: shared types and constants for the binary16 adder
// Holds field masks, the inter-stage records and the leading-zero function.
// ============================================================================
`default_nettype none

package hpa_pkg;

    localparam logic [15:0] SGN_BIT    = 16'h8000;
    localparam logic [15:0] EXP_FIELD  = 16'h7c00;
    localparam logic [15:0] FRAC_FIELD = 16'h03ff;
    localparam logic [15:0] TOP_BIT    = 16'h2000;
    localparam logic [15:0] HIDDEN_BIT = 16'h0400;
    localparam logic [15:0] EXP_BIAS   = 16'h000f;

    // Record after alignment.
    typedef struct packed {
        logic [15:0] as;
        logic [15:0] bs;
        logic [15:0] ae;
        logic [15:0] a_m;
        logic [15:0] b_m;
        logic        lead_inf;
    } align_t;

    // Record after the magnitude add or subtract.
    // The leading sign is kept apart from the result sign for the infinity case.
    typedef struct packed {
        logic [15:0] as;
        logic [15:0] zs;
        logic [15:0] ae;
        logic [15:0] m_add;
        logic [15:0] e_add;
        logic        lead_inf;
        logic        exact_zero;
    } addsub_t;

    // Count of leading zeros in a 16-bit word (16 for zero).
    function automatic logic [4:0] lead_zeros16(input logic [15:0] v);
        logic [4:0] n;
        logic       seen;
        n    = 5'd0;
        seen = 1'b0;
        for (int i = 15; i >= 0; i--)
        begin
            if (v[i])
            begin
                seen = 1'b1;
            end
            if (!seen)
            begin
                n = n + 5'd1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hpa_stream_if.sv
// ============================================================================
// hpa_stream_if: valid/ready channel with a generic payload
// One transfer happens at each rising edge where valid and ready are high.
// ============================================================================
`default_nettype none

interface hpa_stream_if #(
    parameter int WIDTH = 16
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hpa_align.sv
// ============================================================================
// hpa_align: stage one of the adder
// Orders the operands, restores hidden bits and aligns the trailing mantissa.
// ============================================================================
`default_nettype none

module hpa_align (
    input  wire logic [15:0]     x,
    input  wire logic [15:0]     y,
    output hpa_pkg::align_t      res
);
    logic        swap;
    logic [15:0] xe, ye, as, ae, am0, bs, be, bm0, amh, bmh;
    logic [15:0] sa_sub, sa_gap, sa, b_wide, b_shift, lost_mask;
    logic [15:0] xs, ys, xm, ym;

    always_comb
    begin
        xs = x & hpa_pkg::SGN_BIT;
        ys = y & hpa_pkg::SGN_BIT;
        xe = x & hpa_pkg::EXP_FIELD;
        ye = y & hpa_pkg::EXP_FIELD;
        xm = x & hpa_pkg::FRAC_FIELD;
        ym = y & hpa_pkg::FRAC_FIELD;
        swap = ye > xe;
        as  = swap ? ys : xs;
        ae  = swap ? ye : xe;
        am0 = swap ? ym : xm;
        bs  = swap ? xs : ys;
        be  = swap ? xe : ye;
        bm0 = swap ? xm : ym;
        amh = am0 | ((ae != 16'd0) ? hpa_pkg::HIDDEN_BIT : 16'd0);
        bmh = bm0 | ((be != 16'd0) ? hpa_pkg::HIDDEN_BIT : 16'd0);

        // Shift amount, with the special subnormal-trailing case.
        sa_sub = (ae - hpa_pkg::EXP_BIAS - 16'd1) >> 10;
        sa_gap = (ae - be) >> 10;
        sa     = (be == 16'd0 && ae != 16'd0) ? sa_sub : sa_gap;

        b_wide    = bmh << 3;
        b_shift   = (sa >= 16'd16) ? 16'd0 : (b_wide >> sa[3:0]);
        lost_mask = ((sa >= 16'd16) ? 16'd0 : (16'd1 << sa[3:0])) - 16'd1;

        res.as       = as;
        res.bs       = bs;
        res.ae       = ae;
        res.a_m      = amh << 3;
        res.b_m      = b_shift | {15'd0, (b_wide & lost_mask) != 16'd0};
        res.lead_inf = (ae | am0) == hpa_pkg::EXP_FIELD;
    end
endmodule

`default_nettype wire

FILE: rtl/core/hpa_addsub.sv
// ============================================================================
// hpa_addsub: stage two of the adder
// Adds or subtracts the aligned magnitudes and renormalizes a difference.
// ============================================================================
`default_nettype none

module hpa_addsub (
    input  wire hpa_pkg::align_t  a,
    output hpa_pkg::addsub_t      res
);
    logic        opp, a_big, to_sub, any_norm;
    logic [15:0] msum, mag, a_eb, norm_sa, sub_sa, m_n, e_n, m_diff, e_diff;

    always_comb
    begin
        opp   = (a.as ^ a.bs) != 16'd0;
        a_eb  = a.ae >> 10;
        msum  = a.a_m + a.b_m;
        a_big = a.a_m > a.b_m;
        mag   = a_big ? (a.a_m - a.b_m) : (a.b_m - a.a_m);

        // Normalize the difference, stopping at the subnormal limit.
        norm_sa  = {11'd0, hpa_pkg::lead_zeros16(mag)} - 16'd1;
        to_sub   = a_eb < norm_sa;
        sub_sa   = a_eb - 16'd1;
        if (to_sub)
        begin
            m_n = (sub_sa >= 16'd16) ? 16'd0 : (mag << sub_sa[3:0]);
        end
        else
        begin
            m_n = (norm_sa >= 16'd16) ? 16'd0 : (mag << norm_sa[3:0]);
        end
        e_n      = to_sub ? 16'd0 : (a_eb - norm_sa);
        any_norm = a_eb != 16'd0;
        m_diff   = any_norm ? m_n : mag;
        e_diff   = any_norm ? e_n : a_eb;

        res.as         = a.as;
        res.zs         = opp ? (a_big ? a.as : a.bs) : a.as;
        res.ae         = a.ae;
        res.m_add      = opp ? m_diff : msum;
        res.e_add      = opp ? e_diff : a_eb;
        res.lead_inf   = a.lead_inf;
        res.exact_zero = opp && (m_diff == 16'd0);
    end
endmodule

`default_nettype wire

FILE: rtl/core/hpa_round.sv
// ============================================================================
// hpa_round: stage three of the adder
// Handles carry, rounds on the low bits, packs and applies special cases.
// ============================================================================
`default_nettype none

module hpa_round (
    input  wire hpa_pkg::addsub_t  a,
    output logic [15:0]            sum
);
    logic [15:0] m_nh, e_nh, e_fix, m_rnd, e_rnd, packed_w;
    logic        carry;

    always_comb
    begin
        carry = a.m_add[14];
        m_nh  = carry ? (a.m_add >> 1) : a.m_add;
        e_nh  = a.e_add + {15'd0, carry};
        e_fix = e_nh + {15'd0, (a.ae == 16'd0) && ((m_nh & hpa_pkg::TOP_BIT) != 16'd0)};
        m_rnd = m_nh + {13'd0, m_nh[2:0]};
        e_rnd = e_fix + {15'd0, m_rnd[14]};
        packed_w = a.zs | (e_rnd << 10) | ((m_rnd >> 3) & hpa_pkg::FRAC_FIELD);
        if (a.exact_zero)
        begin
            sum = 16'd0;
        end
        else if (a.lead_inf)
        begin
            // An infinite leading operand keeps its own sign.
            sum = a.as | hpa_pkg::EXP_FIELD;
        end
        else
        begin
            sum = packed_w;
        end
    end
endmodule

`default_nettype wire

FILE: rtl/core/half_precision_adder.sv
// ============================================================================
// half_precision_adder: pipelined IEEE binary16 adder
// Three register stages: align, add/normalize, round/pack.
// ============================================================================
// Usage:
//   in_ch carries {operand_x, operand_y} as data[31:16] and data[15:0].
//   out_ch carries the 16-bit sum. Each transfer is one valid/ready handshake.
//   The result reaches out_ch through the s1_reg, s2_reg and s3_reg stages
//   after the input transfer. Throughput is one operand pair per cycle while
//   the receiver does not stall, since every stage advances in the same cycle
//   in which the stage after it is emptied.
//   The pipeline advances whenever its output register is empty or taken,
//   so when the receiver stalls a full stage holds, an empty one still fills,
//   and in_ch.ready drops only once all stages hold data; nothing is lost or repeated.
//   Reset clears the valid bits of all stages; no item is in flight after
//   it. The block has no state between items and no configuration.
// ============================================================================
`default_nettype none

module half_precision_adder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hpa_stream_if.sink   in_ch,
    hpa_stream_if.source out_ch
);
    hpa_pkg::align_t  s1_next, s1_reg;
    hpa_pkg::addsub_t s2_next, s2_reg;
    logic [15:0]      s3_next, s3_reg;
    logic             v1_reg, v2_reg, v3_reg;
    logic             adv3, adv2, adv1;

    // Stall chain: a stage moves when the one after it moves or is empty.
    assign adv3 = !v3_reg || out_ch.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ch.ready  = adv1;
    assign out_ch.valid = v3_reg;
    assign out_ch.data  = s3_reg;

    hpa_align  u_align  (.x(in_ch.data[31:16]), .y(in_ch.data[15:0]), .res(s1_next));
    hpa_addsub u_addsub (.a(s1_reg), .res(s2_next));
    hpa_round  u_round  (.a(s2_reg), .sum(s3_next));

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_ch.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv1) s1_reg <= s1_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3) s3_reg <= s3_next;
    end
endmodule

`default_nettype wire
